### rtl/core/fwess_pkg.sv
// Package for the four-wheel encoder speed sampler.
// Field widths, register indexes, request codes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package fwess_pkg;

   localparam int NumWheels  = 4;
   localparam int WheelWidth = $clog2(NumWheels);
   localparam int CountWidth = 16;
   localparam int TimeWidth  = 32;
   localparam int SpeedWidth = 26;
   localparam int MaskWidth  = NumWheels;
   localparam int PeriodWidth = 16;

   // dividend: |delta| * 1000 < 2^25; divisor saturates at 2^31 - 1
   localparam int NumWidth = 25;
   localparam int DivWidth = 31;
   localparam int CntWidth = $clog2(NumWidth);

   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CsrReverseMask  = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrSamplePeriod = 1'b1;

   localparam logic ReqStart = 1'b0;
   localparam logic ReqPoll  = 1'b1;

   localparam logic [MaskWidth-1:0]   ReverseMaskReset  = 4'd10;
   localparam logic [PeriodWidth-1:0] SamplePeriodReset = 16'd100;

endpackage

### rtl/core/four_wheel_encoder_speed_sampler_top.sv
// Top level of the four-wheel encoder speed sampler.
// Depends on fwess_pkg.
`timescale 1ns / 1ps

// Usage
//   req_ channel: one item per transfer, req_type selects start (capture
//   baseline counts and time) or poll. A start transfer gives no result and
//   the block is ready again in the next cycle.
//   A poll on a ready block whose elapsed time reaches the sample period gives
//   four rsp_ transfers, wheels 0 to 3, rsp_last high on wheel 3. Any other
//   poll is dropped in the cycle after its transfer, with no state change.
//   Each wheel passes through StCalc, which forms the delta and |delta| * 1000,
//   StDiv, a bit-serial restoring divide (one quotient bit a cycle through a
//   31-bit compare and subtract), and StEmit, which loads the output register.
//   A stalled receiver holds the output register; the divider finishes the
//   next wheel and waits. The last result may sit in the output register
//   while the next request is taken.
//   csr_ channel: index 0 reverse mask, index 1 sample period; always
//   ready, write only while no poll is in progress.
//   Reset (synchronous, active high) clears the baseline and the ready flag,
//   drops any pending result and restores the register defaults.

module four_wheel_encoder_speed_sampler_top
   import fwess_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   input  logic [TimeWidth-1:0]         req_now_ms,
   input  logic [CountWidth-1:0]        req_count_fl,
   input  logic [CountWidth-1:0]        req_count_fr,
   input  logic [CountWidth-1:0]        req_count_rl,
   input  logic [CountWidth-1:0]        req_count_rr,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [WheelWidth-1:0]        rsp_wheel_index,
   output logic [CountWidth-1:0]        rsp_reading,
   output logic signed [CountWidth-1:0] rsp_count_change,
   output logic                         rsp_moving,
   output logic signed [SpeedWidth-1:0] rsp_wheel_rate,
   output logic [TimeWidth-1:0]         rsp_interval_ms,
   output logic                         rsp_last,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CsrIndexWidth-1:0]     csr_index,
   input  logic [CsrDataWidth-1:0]      csr_wdata
);

   typedef enum logic [2:0] {
      StIdle,
      StCheck,
      StCalc,
      StDiv,
      StEmit
   } state_type;

   localparam logic [CntWidth-1:0]   CntLast = CntWidth'(NumWidth - 1);
   localparam logic [WheelWidth-1:0] WheelLast = WheelWidth'(NumWheels - 1);
   localparam logic [DivWidth-1:0]   DivMax = {DivWidth{1'b1}};

   state_type state_ff, state_in;
   logic ready_flag_ff, ready_flag_in;
   logic [MaskWidth-1:0] reverse_mask_ff, reverse_mask_in;
   logic [PeriodWidth-1:0] period_ff, period_in;
   logic [WheelWidth-1:0] wheel_ff, wheel_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;

   // rotating count lines: slot 0 is the wheel being worked on
   logic [CountWidth-1:0] cur_ff [NumWheels];
   logic [CountWidth-1:0] cur_in [NumWheels];
   logic [CountWidth-1:0] prev_ff [NumWheels];
   logic [CountWidth-1:0] prev_in [NumWheels];

   logic [TimeWidth-1:0] now_ff, now_in;
   logic [TimeWidth-1:0] last_time_ff, last_time_in;
   logic [TimeWidth-1:0] interval_ff, interval_in;
   logic [DivWidth-1:0] div_ff, div_in;
   logic zero_ff, zero_in;

   logic [CountWidth-1:0] raw_ff, raw_in;
   logic [CountWidth-1:0] delta_ff, delta_in;
   logic moving_ff, moving_in;
   logic neg_ff, neg_in;
   logic [NumWidth-1:0] nq_ff, nq_in;
   logic [DivWidth-1:0] rem_ff, rem_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [WheelWidth-1:0] rsp_wheel_ff, rsp_wheel_in;
   logic [CountWidth-1:0] rsp_raw_ff, rsp_raw_in;
   logic [CountWidth-1:0] rsp_delta_ff, rsp_delta_in;
   logic rsp_moving_ff, rsp_moving_in;
   logic [SpeedWidth-1:0] rsp_speed_ff, rsp_speed_in;
   logic [TimeWidth-1:0] rsp_interval_ff, rsp_interval_in;
   logic rsp_last_ff, rsp_last_in;

   // datapath terms
   logic [TimeWidth-1:0] elapsed;
   logic [CountWidth-1:0] diff;
   logic [CountWidth:0] d_sext, d_val, d_mag;
   logic [SpeedWidth-1:0] product;
   logic [DivWidth:0] trial, trial_sub;
   logic trial_geq;
   logic [SpeedWidth-1:0] quot_ext;

   assign req_ready = (state_ff == StIdle);
   assign csr_ready = 1'b1;

   always_comb begin
      elapsed = now_ff - last_time_ff;

      diff   = cur_ff[0] - prev_ff[0];
      d_sext = {diff[CountWidth-1], diff};
      d_val  = reverse_mask_ff[wheel_ff] ? (~d_sext + 1'b1) : d_sext;
      d_mag  = d_val[CountWidth] ? (~d_val + 1'b1) : d_val;
      // x * 1000 = x * 1024 - x * 16 - x * 8
      product = {d_mag[CountWidth-1:0], 10'b0}
              - {6'b0, d_mag[CountWidth-1:0], 4'b0}
              - {7'b0, d_mag[CountWidth-1:0], 3'b0};

      trial     = {rem_ff, nq_ff[NumWidth-1]};
      trial_geq = (trial >= {1'b0, div_ff});
      trial_sub = trial - {1'b0, div_ff};

      quot_ext = {{(SpeedWidth - NumWidth){1'b0}}, nq_ff};
   end

   always_comb begin
      state_in        = state_ff;
      ready_flag_in   = ready_flag_ff;
      reverse_mask_in = reverse_mask_ff;
      period_in       = period_ff;
      wheel_in        = wheel_ff;
      cnt_in          = cnt_ff;
      cur_in          = cur_ff;
      prev_in         = prev_ff;
      now_in          = now_ff;
      last_time_in    = last_time_ff;
      interval_in     = interval_ff;
      div_in          = div_ff;
      zero_in         = zero_ff;
      raw_in          = raw_ff;
      delta_in        = delta_ff;
      moving_in       = moving_ff;
      neg_in          = neg_ff;
      nq_in           = nq_ff;
      rem_in          = rem_ff;
      rsp_wheel_in    = rsp_wheel_ff;
      rsp_raw_in      = rsp_raw_ff;
      rsp_delta_in    = rsp_delta_ff;
      rsp_moving_in   = rsp_moving_ff;
      rsp_speed_in    = rsp_speed_ff;
      rsp_interval_in = rsp_interval_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      if (csr_valid) begin
         case (csr_index)
            CsrReverseMask:  reverse_mask_in = csr_wdata[MaskWidth-1:0];
            CsrSamplePeriod: period_in = csr_wdata[PeriodWidth-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               if (req_type == ReqStart) begin
                  prev_in[0]    = req_count_fl;
                  prev_in[1]    = req_count_fr;
                  prev_in[2]    = req_count_rl;
                  prev_in[3]    = req_count_rr;
                  last_time_in  = req_now_ms;
                  ready_flag_in = 1'b1;
               end else begin
                  cur_in[0] = req_count_fl;
                  cur_in[1] = req_count_fr;
                  cur_in[2] = req_count_rl;
                  cur_in[3] = req_count_rr;
                  now_in    = req_now_ms;
                  state_in  = StCheck;
               end
            end
         end

         StCheck: begin
            if (!ready_flag_ff || elapsed < {{(TimeWidth - PeriodWidth){1'b0}}, period_ff}) begin
               state_in = StIdle;
            end else begin
               last_time_in = now_ff;
               interval_in  = elapsed;
               div_in       = elapsed[TimeWidth-1] ? DivMax : elapsed[DivWidth-1:0];
               zero_in      = (elapsed == '0);
               wheel_in     = '0;
               state_in     = StCalc;
            end
         end

         StCalc: begin
            raw_in    = cur_ff[0];
            delta_in  = d_val[CountWidth-1:0];
            moving_in = (d_val != '0);
            neg_in    = d_val[CountWidth];
            nq_in     = product[NumWidth-1:0];
            rem_in    = '0;
            cnt_in    = '0;
            // advance both lines; the used reading becomes the new baseline
            for (int i = 0; i < NumWheels - 1; i++) begin
               cur_in[i]  = cur_ff[i + 1];
               prev_in[i] = prev_ff[i + 1];
            end
            cur_in[NumWheels-1]  = cur_ff[0];
            prev_in[NumWheels-1] = cur_ff[0];
            state_in = StDiv;
         end

         StDiv: begin
            rem_in = trial_geq ? trial_sub[DivWidth-1:0] : trial[DivWidth-1:0];
            nq_in  = {nq_ff[NumWidth-2:0], trial_geq};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntLast) begin
               state_in = StEmit;
            end
         end

         StEmit: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_wheel_in    = wheel_ff;
               rsp_raw_in      = raw_ff;
               rsp_delta_in    = delta_ff;
               rsp_moving_in   = moving_ff;
               rsp_interval_in = interval_ff;
               rsp_last_in     = (wheel_ff == WheelLast);
               if (zero_ff) begin
                  rsp_speed_in = '0;
               end else if (neg_ff) begin
                  rsp_speed_in = ~quot_ext + 1'b1;
               end else begin
                  rsp_speed_in = quot_ext;
               end
               if (wheel_ff == WheelLast) begin
                  state_in = StIdle;
               end else begin
                  wheel_in = wheel_ff + 1'b1;
                  state_in = StCalc;
               end
            end
         end

         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff          <= cur_in;
      now_ff          <= now_in;
      interval_ff     <= interval_in;
      div_ff          <= div_in;
      zero_ff         <= zero_in;
      raw_ff          <= raw_in;
      delta_ff        <= delta_in;
      moving_ff       <= moving_in;
      neg_ff          <= neg_in;
      nq_ff           <= nq_in;
      rem_ff          <= rem_in;
      cnt_ff          <= cnt_in;
      rsp_wheel_ff    <= rsp_wheel_in;
      rsp_raw_ff      <= rsp_raw_in;
      rsp_delta_ff    <= rsp_delta_in;
      rsp_moving_ff   <= rsp_moving_in;
      rsp_speed_ff    <= rsp_speed_in;
      rsp_interval_ff <= rsp_interval_in;
      rsp_last_ff     <= rsp_last_in;
      if (reset) begin
         state_ff        <= StIdle;
         ready_flag_ff   <= 1'b0;
         reverse_mask_ff <= ReverseMaskReset;
         period_ff       <= SamplePeriodReset;
         wheel_ff        <= '0;
         last_time_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < NumWheels; i++) begin
            prev_ff[i] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         ready_flag_ff   <= ready_flag_in;
         reverse_mask_ff <= reverse_mask_in;
         period_ff       <= period_in;
         wheel_ff        <= wheel_in;
         last_time_ff    <= last_time_in;
         rsp_valid_ff    <= rsp_valid_in;
         prev_ff         <= prev_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_wheel_index  = rsp_wheel_ff;
   assign rsp_reading      = rsp_raw_ff;
   assign rsp_count_change = $signed(rsp_delta_ff);
   assign rsp_moving       = rsp_moving_ff;
   assign rsp_wheel_rate   = $signed(rsp_speed_ff);
   assign rsp_interval_ms  = rsp_interval_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

### tb/four_wheel_encoder_speed_sampler_top_tb.sv
// Testbench for four_wheel_encoder_speed_sampler_top: directed and random traffic
// with a local wheel speed predictor and in-order result checking.
// Depends on fwess_pkg and the top-level RTL.
`timescale 1ns / 1ps

module four_wheel_encoder_speed_sampler_top_tb;
   import fwess_pkg::*;

   localparam int StallLimit   = 5000;
   localparam int SettleCycles = 200;
   localparam int DropSettle   = 4;
   localparam int HoldCycles   = 600;

   typedef struct packed {
      logic                                 kind;
      logic [TimeWidth-1:0]                 now_ms;
      logic [NumWheels-1:0][CountWidth-1:0] counts;
   } encoder_req_type;

   typedef struct packed {
      logic [WheelWidth-1:0] wheel;
      logic [CountWidth-1:0] raw;
      logic [CountWidth-1:0] delta;
      logic                  moving;
      logic [SpeedWidth-1:0] speed;
      logic [TimeWidth-1:0]  interval;
      logic                  last;
   } wheel_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_type = ReqStart;
   logic [TimeWidth-1:0]         req_now_ms = '0;
   logic [CountWidth-1:0]        req_count_fl = '0;
   logic [CountWidth-1:0]        req_count_fr = '0;
   logic [CountWidth-1:0]        req_count_rl = '0;
   logic [CountWidth-1:0]        req_count_rr = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [WheelWidth-1:0]        rsp_wheel_index;
   logic [CountWidth-1:0]        rsp_reading;
   logic signed [CountWidth-1:0] rsp_count_change;
   logic                         rsp_moving;
   logic signed [SpeedWidth-1:0] rsp_wheel_rate;
   logic [TimeWidth-1:0]         rsp_interval_ms;
   logic                         rsp_last;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CsrIndexWidth-1:0]     csr_index = CsrReverseMask;
   logic [CsrDataWidth-1:0]      csr_wdata = '0;

   // predictor state and register copies
   logic [NumWheels-1:0][CountWidth-1:0] base_counts = '0;
   logic [TimeWidth-1:0]                 base_time = '0;
   logic                                 baseline_valid = 1'b0;
   logic [MaskWidth-1:0]                 rev_mask = ReverseMaskReset;
   logic [PeriodWidth-1:0]               period = SamplePeriodReset;

   wheel_result_type pending_wheel_results[$];
   int               mismatches = 0;
   int               useful_items = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               rsp_hold_cycles = 0;
   int               stall_cycles = 0;

   four_wheel_encoder_speed_sampler_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_now_ms       (req_now_ms),
      .req_count_fl     (req_count_fl),
      .req_count_fr     (req_count_fr),
      .req_count_rl     (req_count_rl),
      .req_count_rr     (req_count_rr),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_wheel_index  (rsp_wheel_index),
      .rsp_reading      (rsp_reading),
      .rsp_count_change (rsp_count_change),
      .rsp_moving       (rsp_moving),
      .rsp_wheel_rate   (rsp_wheel_rate),
      .rsp_interval_ms  (rsp_interval_ms),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h, wanted %h", $time, what, got, want);
      mismatches++;
   endtask

   // Start captures the baseline; a poll that is due yields one result per wheel.
   task automatic predict_wheel_speeds(input encoder_req_type r, output int produced);
      logic [TimeWidth-1:0]  interval;
      logic [CountWidth-1:0] diff;
      int                    delta;
      longint                divisor;
      longint                quotient;
      wheel_result_type      res;
      produced = 0;
      if (r.kind == ReqStart) begin
         base_counts = r.counts;
         base_time = r.now_ms;
         baseline_valid = 1'b1;
         return;
      end
      if (!baseline_valid) return;
      interval = r.now_ms - base_time;
      if (interval < period) return;
      for (int w = 0; w < NumWheels; w++) begin
         diff = r.counts[w] - base_counts[w];
         delta = $signed(diff);
         if (rev_mask[w]) delta = -delta;
         if (interval > 32'h7FFF_FFFF) divisor = 64'h7FFF_FFFF;
         else divisor = longint'(interval);
         // zero interval gives zero speed
         if (interval == 0) quotient = 0;
         else quotient = (longint'(delta) * 1000) / divisor;
         res.wheel = WheelWidth'(w);
         res.raw = r.counts[w];
         res.delta = delta[CountWidth-1:0];
         res.moving = (delta != 0);
         res.speed = quotient[SpeedWidth-1:0];
         res.interval = interval;
         res.last = (w == NumWheels - 1);
         pending_wheel_results.push_back(res);
      end
      base_counts = r.counts;
      base_time = r.now_ms;
      produced = NumWheels;
   endtask

   function automatic encoder_req_type make_req(input logic kind, input logic [31:0] now,
                                                input logic [15:0] fl, fr, rl, rr);
      encoder_req_type r;
      r.kind = kind;
      r.now_ms = now;
      r.counts = {rr, rl, fr, fl};
      return r;
   endfunction

   // Random counter readings for a start or an arbitrary poll.
   function automatic encoder_req_type random_req(input logic kind);
      return make_req(kind, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
   endfunction

   // Poll that is due, with realistic count movement from the current baseline.
   function automatic encoder_req_type due_poll();
      encoder_req_type       r;
      logic [CountWidth-1:0] step;
      r.kind = ReqPoll;
      r.now_ms = base_time + 32'(period) + $urandom_range(0, 20);
      for (int w = 0; w < NumWheels; w++) begin
         step = 16'($urandom_range(0, 4000));
         case ($urandom_range(9))
            0: r.counts[w] = 16'($urandom);
            1: r.counts[w] = base_counts[w];
            default: r.counts[w] = base_counts[w] + step - 16'd2000;
         endcase
      end
      return r;
   endfunction

   task automatic send_request(input encoder_req_type r);
      int produced;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_type     <= r.kind;
      req_now_ms   <= r.now_ms;
      req_count_fl <= r.counts[0];
      req_count_fr <= r.counts[1];
      req_count_rl <= r.counts[2];
      req_count_rr <= r.counts[3];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_wheel_speeds(r, produced);
      if (r.kind == ReqStart || produced > 0) useful_items++;
   endtask

   // Drop valid and hold until every predicted result has been seen.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_wheel_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] idx,
                                 input logic [CsrDataWidth-1:0] data);
      wait_for_results();
      // a dropped poll may still be in flight
      repeat (DropSettle) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CsrReverseMask) rev_mask = data[MaskWidth-1:0];
      else period = data[PeriodWidth-1:0];
   endtask

   task automatic test_poll_before_start();
      send_request(make_req(ReqPoll, 32'h0000_1000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
      send_request(make_req(ReqPoll, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
   endtask

   task automatic test_default_registers();
      send_request(make_req(ReqStart, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_request(make_req(ReqPoll, 32'd99, 16'd5, 16'd5, 16'd5, 16'd5));
      // exact period; rear right reversed from the most negative delta
      send_request(make_req(ReqPoll, 32'd100, 16'd1, 16'd1, 16'hFFFF, 16'h8000));
      send_request(make_req(ReqStart, 32'hFFFF_FFF0, 16'h7FFF, 16'd0, 16'hFFFF, 16'h1234));
      send_request(make_req(ReqStart, 32'hFFFF_FFC0, 16'd0, 16'd0, 16'd0, 16'd0));
      // time wraps through zero
      send_request(make_req(ReqPoll, 32'h0000_0024, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF));
      // divisor saturates
      send_request(make_req(ReqPoll, 32'h8000_002B, 16'h8000, 16'h0000, 16'h7FFF, 16'h0001));
      send_request(make_req(ReqPoll, 32'h8000_002A, 16'h8000, 16'h0000, 16'h7FFF, 16'h0001));
   endtask

   task automatic test_register_extremes();
      write_register(CsrReverseMask, 16'd0);
      write_register(CsrSamplePeriod, 16'd1);
      send_request(make_req(ReqStart, 32'h1234_5678, 16'd0, 16'd0, 16'd0, 16'd0));
      send_request(make_req(ReqPoll, 32'h1234_5679, 16'h7FFF, 16'h8000, 16'd1, 16'd0));
      send_request(make_req(ReqPoll, 32'h1234_5679, 16'd9, 16'd9, 16'd9, 16'd9));
      write_register(CsrReverseMask, 16'd15);
      write_register(CsrSamplePeriod, 16'hFFFF);
      send_request(make_req(ReqPoll, 32'h1235_5677, 16'd3, 16'd3, 16'd3, 16'd3));
      send_request(make_req(ReqPoll, 32'h1235_5678, 16'hFFFF, 16'd0, 16'h8001, 16'h8000));
      write_register(CsrReverseMask, 16'd5);
      write_register(CsrSamplePeriod, 16'd2);
      send_request(make_req(ReqStart, 32'h0000_0000, 16'hAAAA, 16'h5555, 16'h00FF, 16'hFF00));
      send_request(make_req(ReqPoll, 32'h0000_0002, 16'h5555, 16'hAAAA, 16'hFF00, 16'h00FF));
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                      input logic [PeriodWidth-1:0] sample_period,
                                      input int items);
      int              goal;
      int              pick;
      encoder_req_type r;
      write_register(CsrReverseMask, 16'($urandom_range(0, 15)));
      write_register(CsrSamplePeriod, sample_period);
      send_idle_pct = sender_idle;
      recv_idle_pct = receiver_idle;
      goal = useful_items + items;
      while (useful_items < goal) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            r = random_req(ReqStart);
         end else if (pick < 72) begin
            r = due_poll();
         end else if (pick < 82) begin
            r = due_poll();
            r.now_ms = base_time + $urandom_range(0, period - 1);
         end else if (pick < 88) begin
            r = due_poll();
            r.now_ms = base_time + $urandom_range(32'h7FFF_FFFF, 32'hFFFF_FFFF);
         end else begin
            r = random_req(1'($urandom_range(1)));
         end
         // now and then let the results run dry before the next transfer
         if ($urandom_range(99) < 3) wait_for_results();
         send_request(r);
      end
   endtask

   // Receiver holds off while the sender keeps offering polls.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(CsrSamplePeriod, 16'd10);
      send_request(random_req(ReqStart));
      rsp_hold_cycles = HoldCycles;
      repeat (12) send_request(due_poll());
      wait_for_results();
   endtask

   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : result_check
      wheel_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_wheel_results.size() == 0) begin
            report_mismatch("unexpected wheel result", rsp_wheel_index, '0);
         end else begin
            want = pending_wheel_results.pop_front();
            if (rsp_wheel_index !== want.wheel)
               report_mismatch("wheel_index", rsp_wheel_index, want.wheel);
            if (rsp_reading !== want.raw)
               report_mismatch("reading", rsp_reading, want.raw);
            if (rsp_count_change !== want.delta)
               report_mismatch("count_change", rsp_count_change, want.delta);
            if (rsp_moving !== want.moving)
               report_mismatch("moving", rsp_moving, want.moving);
            if (rsp_wheel_rate !== want.speed)
               report_mismatch("wheel_rate", rsp_wheel_rate, want.speed);
            if (rsp_interval_ms !== want.interval)
               report_mismatch("interval_ms", rsp_interval_ms, want.interval);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // Count cycles without any transfer; end the run if the block hangs.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= StallLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_poll_before_start();
      test_default_registers();
      test_register_extremes();
      test_random_traffic(28, 49, SamplePeriodReset, 95);
      test_random_traffic(49, 28, 16'($urandom_range(1, 1000)), 95);
      test_random_traffic(0, 0, 16'd1, 95);
      test_backpressure();
      wait_for_results();
      repeat (SettleCycles) @(posedge clock);
      if (pending_wheel_results.size() != 0)
         report_mismatch("results never produced", '0, pending_wheel_results.size());
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
